// File: rtl/core/rsp_pkg.sv
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
`timescale 1ns / 1ps

package rsp_pkg;

	localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;
	localparam logic [5:0] PARITY_RESET   = 6'd10;

	typedef struct packed {
		logic       gen_init;
		logic       gen_step;
		logic       enc_step;
		logic       enc_last;
		logic       rem_clear;
		logic       out_shift;
		logic [7:0] operand;
	} cell_ctrl_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] a;
		logic [7:0] r;
		a = x;
		r = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (y[k]) begin
				r = r ^ a;
			end
			a = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LOW : 8'h00);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/rsp_cell.sv
// One cell of the encoder chain: generator coefficient, remainder byte and output byte.
`timescale 1ns / 1ps

module rsp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rsp_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]        seed,
	input  logic [7:0]        g_prev,
	input  logic [7:0]        r_prev,
	input  logic [7:0]        o_prev,
	output logic [7:0]        g_out,
	output logic [7:0]        r_out,
	output logic [7:0]        o_out
);

	logic [7:0] g_q;
	logic [7:0] r_q;
	logic [7:0] o_q;
	logic [7:0] prod;
	logic [7:0] r_next;

	assign prod   = rsp_pkg::gf_mul(g_q, ctrl.operand);
	assign r_next = r_prev ^ prod;

	always_ff @(posedge clk) begin
		if (ctrl.gen_init) begin
			g_q <= seed;
		end else if (ctrl.gen_step) begin
			g_q <= g_prev ^ prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= 8'h00;
		end else if (ctrl.rem_clear) begin
			r_q <= 8'h00;
		end else if (ctrl.enc_step) begin
			r_q <= ctrl.enc_last ? 8'h00 : r_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.enc_step && ctrl.enc_last) begin
			o_q <= r_next;
		end else if (ctrl.out_shift) begin
			o_q <= o_prev;
		end
	end

	assign g_out = g_q;
	assign r_out = r_q;
	assign o_out = o_q;

endmodule

// File: rtl/core/reed_solomon_parity_encoder_top.sv
// Top level of the Reed-Solomon GF(256) systematic parity encoder built from a chain of cells.
// Throughput: one data byte per cycle while s_tready is high; parity bytes drain one per
// cycle while m_tready is high, as the next codeword's data keeps flowing in through the
// separate output shift chain. The first parity byte is valid in the cycle after the last
// data transfer; n parity bytes (n = effective parity count) are sent in all. A last byte is held
// off only while the previous codeword's parity has not yet drained. After reset and each parity_count
// write the generator is rebuilt in INIT and BUILD with s_tready low; the remainder resets to zero.
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_top #(
	parameter int MAX_PARITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,    // parity_count
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,      // [7:0] data_byte
	input  logic       s_tlast,      // last_data
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,      // [7:0] parity_byte
	output logic       m_tlast       // last_parity
);

	localparam int CW = $clog2(MAX_PARITY + 1);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_BUILD = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0]          state_q;
	logic [5:0]          parity_q;
	logic [CW-1:0]       iter_q;
	logic [CW-1:0]       cnt_q;
	logic [7:0]          root_q;
	logic [CW-1:0]       n_eff;
	logic [7:0]          fb;
	logic                drain_free;
	logic                in_xfer;
	logic                out_xfer;
	rsp_pkg::cell_ctrl_t ctrl;

	logic [7:0] g_ch [MAX_PARITY+1];
	logic [7:0] r_ch [MAX_PARITY+1];
	logic [7:0] o_ch [MAX_PARITY+1];

	always_comb begin
		if (parity_q == 6'd0) begin
			n_eff = CW'(1);
		end else if (int'(parity_q) > MAX_PARITY) begin
			n_eff = CW'(MAX_PARITY);
		end else begin
			n_eff = CW'(parity_q);
		end
	end

	assign g_ch[0] = 8'h00;
	assign r_ch[0] = 8'h00;
	assign o_ch[0] = 8'h00;

	assign fb         = s_tdata ^ r_ch[n_eff];
	assign drain_free = (cnt_q == '0) || ((cnt_q == CW'(1)) && m_tready);
	assign s_tready   = (state_q == ST_RUN) && (!s_tlast || drain_free);
	assign in_xfer    = s_tvalid && s_tready;
	assign out_xfer   = m_tvalid && m_tready;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = o_ch[n_eff];
	assign m_tlast  = (cnt_q == CW'(1));

	always_comb begin
		ctrl.gen_init  = (state_q == ST_INIT);
		ctrl.gen_step  = (state_q == ST_BUILD);
		ctrl.rem_clear = (state_q == ST_INIT);
		ctrl.enc_step  = in_xfer;
		ctrl.enc_last  = s_tlast;
		ctrl.out_shift = out_xfer;
		ctrl.operand   = (state_q == ST_BUILD) ? root_q : fb;
	end

	for (genvar k = 0; k < MAX_PARITY; k++) begin : g_cell
		rsp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.seed   ((k == 0) ? 8'h01 : 8'h00),
			.g_prev (g_ch[k]),
			.r_prev (r_ch[k]),
			.o_prev (o_ch[k]),
			.g_out  (g_ch[k+1]),
			.r_out  (r_ch[k+1]),
			.o_out  (o_ch[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= rsp_pkg::PARITY_RESET;
		end else if (cfg_we) begin
			parity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			iter_q  <= '0;
			root_q  <= 8'h01;
		end else if (cfg_we) begin
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					state_q <= ST_BUILD;
					iter_q  <= CW'(1);
					root_q  <= 8'h01;
				end
				ST_BUILD: begin
					root_q <= rsp_pkg::gf_mul(root_q, 8'h02);
					iter_q <= iter_q + CW'(1);
					if (iter_q == n_eff) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_xfer && s_tlast) begin
			cnt_q <= n_eff;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	a_ready_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_RUN)
		else $error("input accepted outside run state");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tlast && !cfg_we) |=> (m_tvalid && cnt_q == n_eff))
		else $error("last data transfer did not load parity drain");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= n_eff)
		else $error("drain count exceeds parity count");

	a_build_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUILD |-> (iter_q <= n_eff && iter_q != '0))
		else $error("generator build overran");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_tlast && !in_xfer) |=> !m_tvalid)
		else $error("output still valid after final parity transfer");

endmodule
